/* hw/rtl/mtlf_pkg.sv */
// Package for the magnet-triggered LED fader: widths, register indexes,
// reset values and the shared tick-timer function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtlf_pkg;

    // Datapath widths
    localparam int COUNT_WIDTH = 16;
    localparam int LEVEL_WIDTH = 8;
    localparam int REG8_WIDTH  = 8;
    localparam int REG16_WIDTH = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DUTY_WIDTH  = 8;

    // Compare widths wide enough for both operands
    localparam int CNT_CMP_W = (COUNT_WIDTH > REG16_WIDTH) ? COUNT_WIDTH : REG16_WIDTH;
    localparam int LVL_CMP_W = (LEVEL_WIDTH > REG8_WIDTH) ? LEVEL_WIDTH : REG8_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Stream data widths in bits
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Register reset values
    localparam logic [REG8_WIDTH-1:0]  RST_FULL_LEVEL    = 8'd250;
    localparam logic [REG16_WIDTH-1:0] RST_QUICK_STEP    = 16'd7;
    localparam logic [REG16_WIDTH-1:0] RST_SLOW_STEP     = 16'd27;
    localparam logic [REG8_WIDTH-1:0]  RST_SLOW_BELOW    = 8'd40;
    localparam logic [REG16_WIDTH-1:0] RST_OFF_HOLD      = 16'd4005;
    localparam logic [REG16_WIDTH-1:0] RST_SAMPLE_PERIOD = 16'd306;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_LEVEL    = 3'd0,
        CFG_QUICK_STEP    = 3'd1,
        CFG_SLOW_STEP     = 3'd2,
        CFG_SLOW_BELOW    = 3'd3,
        CFG_OFF_HOLD      = 3'd4,
        CFG_SAMPLE_PERIOD = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                   elapsed;
        logic [COUNT_WIDTH-1:0] count;
    } t_timer;

    // Saturating tick counter: elapses when the new value reaches the
    // period or cannot count further, then restarts from zero.
    function automatic t_timer tick_timer(input logic [COUNT_WIDTH-1:0] count,
                                          input logic [REG16_WIDTH-1:0] period);
        logic [COUNT_WIDTH-1:0] c;
        t_timer                 res;
        c = (count != CNT_MAX) ? count + 1'b1 : count;
        res.elapsed = (CNT_CMP_W'(c) >= CNT_CMP_W'(period)) || (c == CNT_MAX);
        res.count   = res.elapsed ? '0 : c;
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/magnet_triggered_led_fader.sv */
// Top level of the magnet-triggered LED fader: input register, tick update
// logic, result register and configuration registers.
// Depends on mtlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One item is one millisecond tick carrying the magnet sensor level; each
// tick gives exactly one result with the LED duty, a sleep request pulse and
// the held near flag. The block takes one item per clock cycle while
// downstream keeps tready high: an item is captured in the input register,
// the sampling and shared hold/step timers are updated in one pass of
// compare-and-increment logic, and the result lands in the output register,
// which frees up in the same cycle its item is taken, so a stall only holds
// the input while downstream holds tready low. Write the configuration
// registers through i_cfg_we / i_cfg_index / i_cfg_data only while no tick
// is in flight; the block does not enforce it. Unused indexes are ignored.

module magnet_triggered_led_fader (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration write port
    input  wire                                  i_cfg_we,
    input  wire  [mtlf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [mtlf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Tick input stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [mtlf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [0] magnet_level
    // Result stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [mtlf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [7:0] duty,
                                                                // [8] sleep_request,
                                                                // [9] near_flag
);
    import mtlf_pkg::*;

    // Configuration registers
    logic [REG8_WIDTH-1:0]  r_full_level;
    logic [REG16_WIDTH-1:0] r_quick_step;
    logic [REG16_WIDTH-1:0] r_slow_step;
    logic [REG8_WIDTH-1:0]  r_slow_below;
    logic [REG16_WIDTH-1:0] r_off_hold;
    logic [REG16_WIDTH-1:0] r_sample_period;

    // Fader state
    logic [COUNT_WIDTH-1:0] r_sample_count, n_sample_count;
    logic [COUNT_WIDTH-1:0] r_fade_count, n_fade_count;
    logic [LEVEL_WIDTH-1:0] r_level, n_level;
    logic [LEVEL_WIDTH-1:0] r_target, n_target;
    logic                   r_use_slow, n_use_slow;
    logic                   r_near, n_near;
    logic                   r_holding, n_holding;
    logic                   r_asleep, n_asleep;
    logic                   n_sleep_req;

    // Pipeline registers
    logic                   r_in_valid;
    logic                   r_in_mag;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   process;
    t_timer                 sample_tmr;
    t_timer                 fade_tmr;
    logic [REG16_WIDTH-1:0] step_period;

    // Handshake: work on the held item when the result slot is free
    assign process       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || process;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_level    <= RST_FULL_LEVEL;
            r_quick_step    <= RST_QUICK_STEP;
            r_slow_step     <= RST_SLOW_STEP;
            r_slow_below    <= RST_SLOW_BELOW;
            r_off_hold      <= RST_OFF_HOLD;
            r_sample_period <= RST_SAMPLE_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FULL_LEVEL:    r_full_level    <= i_cfg_data[REG8_WIDTH-1:0];
                CFG_QUICK_STEP:    r_quick_step    <= i_cfg_data[REG16_WIDTH-1:0];
                CFG_SLOW_STEP:     r_slow_step     <= i_cfg_data[REG16_WIDTH-1:0];
                CFG_SLOW_BELOW:    r_slow_below    <= i_cfg_data[REG8_WIDTH-1:0];
                CFG_OFF_HOLD:      r_off_hold      <= i_cfg_data[REG16_WIDTH-1:0];
                CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[REG16_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Tick update: wake check while asleep, else sampling first, then hold or step
    always_comb begin
        n_sample_count = r_sample_count;
        n_fade_count   = r_fade_count;
        n_level        = r_level;
        n_target       = r_target;
        n_use_slow     = r_use_slow;
        n_near         = r_near;
        n_holding      = r_holding;
        n_asleep       = r_asleep;
        n_sleep_req    = 1'b0;
        sample_tmr     = '0;
        fade_tmr       = '0;
        step_period    = r_use_slow ? r_slow_step : r_quick_step;

        if (r_asleep) begin
            // A high sensor level wakes straight into the near state
            if (r_in_mag) begin
                n_asleep       = 1'b0;
                n_near         = 1'b1;
                n_target       = LEVEL_WIDTH'(r_full_level);
                n_holding      = 1'b0;
                n_sample_count = '0;
                n_fade_count   = '0;
            end
        end else begin
            // Sensor sampling
            sample_tmr     = tick_timer(r_sample_count, r_sample_period);
            n_sample_count = sample_tmr.count;
            if (sample_tmr.elapsed) begin
                if (r_in_mag && !r_near) begin
                    n_near    = 1'b1;
                    n_target  = LEVEL_WIDTH'(r_full_level);
                    n_holding = 1'b0;
                end else if (!r_in_mag && r_near) begin
                    n_near       = 1'b0;
                    n_holding    = 1'b1;
                    n_fade_count = '0;
                end
            end

            if (n_holding) begin
                // Hold brightness until the hold timer runs out
                fade_tmr     = tick_timer(n_fade_count, r_off_hold);
                n_fade_count = fade_tmr.count;
                if (fade_tmr.elapsed) begin
                    n_target  = '0;
                    n_holding = 1'b0;
                end
            end else begin
                // One duty step toward the target
                fade_tmr     = tick_timer(n_fade_count, step_period);
                n_fade_count = fade_tmr.count;
                if (fade_tmr.elapsed) begin
                    if (r_level < n_target) begin
                        n_level = r_level + 1'b1;
                    end else if (r_level > n_target) begin
                        n_level = r_level - 1'b1;
                    end
                    n_use_slow = LVL_CMP_W'(n_level) < LVL_CMP_W'(r_slow_below);
                    if (n_level == '0) begin
                        n_sleep_req = 1'b1;
                        n_asleep    = 1'b1;
                    end
                end
            end
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_fade_count   <= '0;
            r_level        <= '0;
            r_target       <= '0;
            r_use_slow     <= 1'b0;
            r_near         <= 1'b0;
            r_holding      <= 1'b0;
            r_asleep       <= 1'b0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (process) begin
                r_sample_count <= n_sample_count;
                r_fade_count   <= n_fade_count;
                r_level        <= n_level;
                r_target       <= n_target;
                r_use_slow     <= n_use_slow;
                r_near         <= n_near;
                r_holding      <= n_holding;
                r_asleep       <= n_asleep;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mag <= s_axis_tdata[0];
        end
        if (process) begin
            r_out_data <= {{(OUT_TDATA_W - DUTY_WIDTH - 2){1'b0}}, n_near, n_sleep_req,
                           (r_asleep ? {DUTY_WIDTH{1'b0}} : DUTY_WIDTH'(n_level))};
        end
    end

    // Checks
    a_sleep_duty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == '0))
        else $error("sleep request with nonzero duty");

    a_asleep_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_asleep |-> ((r_level == '0) && !r_holding))
        else $error("asleep with lit duty or active hold");

    a_wake_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_asleep && r_in_mag) |=> (r_near && !r_asleep))
        else $error("wake tick did not enter near state");

endmodule

`default_nettype wire
